FILE: hdl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and constants for the lowest free slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

  // Table geometry defaults
  localparam int SLOTS_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths of the command and result beats
  localparam int IN_KEY_W = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;

  // Command kinds
  typedef enum logic {
    KIND_CREATE = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HUNT = 2'b10
  } state_t;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

FILE: hdl/lfsa_cell.sv
// ----------------------------------------------------------------------------
// lfsa_cell
// One table slot. Holds a key and a hunt token; claims the token when its
// key matches, otherwise passes it to the next cell on the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_cell #(
  parameter int KEY_WIDTH = lfsa_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 hunt_in,
  input  wire logic [KEY_WIDTH-1:0] match_key,
  input  wire logic [KEY_WIDTH-1:0] wr_key,
  output logic                      hunt_out,
  output logic                      hit
);

  import lfsa_pkg::*;

  logic                 hunt;
  logic [KEY_WIDTH-1:0] slot;

  // Token claim and hand-off
  assign hit      = hunt && (slot == match_key);
  assign hunt_out = hunt && !hit;

  // Token register, handed along one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt <= 1'b0;
    end else begin
      hunt <= hunt_in;
    end
  end

  // Slot key: empty after reset, rewritten when claimed
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (hit) begin
      slot <= wr_key;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lowest_free_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit
// Slot table with lowest-index allocate on create and lowest-index key match on
// delete, built as a row of slot cells searched by a traveling token.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------
//  command  | start / busy     | kind, key
//  result   | done (strobe)    | slot_index, status, live_count
//
//  A command beat is taken when start is high and busy is low. The token
//  enters cell 0 the next cycle and moves one cell per cycle; the result
//  beat is registered from the cycle in which a cell claims the token or
//  the token leaves the last cell. busy is high while the token travels; a
//  new command may be taken in the cycle the result strobe is high. done
//  lasts one cycle and cannot be stalled. rst (synchronous) empties every
//  slot and clears the live count.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_slot_allocator_unit #(
  parameter int SLOTS     = lfsa_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH = lfsa_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           kind,
  input  wire logic [lfsa_pkg::IN_KEY_W-1:0]  key,
  output logic                                done,
  output logic [lfsa_pkg::IDX_W-1:0]          slot_index,
  output logic [1:0]                          status,
  output logic [lfsa_pkg::CNT_W-1:0]          live_count
);

  import lfsa_pkg::*;

  localparam int PosW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ExtW = (PosW > IDX_W) ? PosW : IDX_W;
  localparam logic [PosW-1:0] PosLast = PosW'(SLOTS - 1);

  state_t               state, state_next;
  logic                 accept;
  logic                 op_delete;
  logic [KEY_WIDTH-1:0] match_key;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [PosW-1:0]      pos;
  logic [ExtW-1:0]      pos_ext;
  logic [CNT_W-1:0]     live_total;
  logic [SLOTS:0]       chain;
  logic [SLOTS-1:0]     hit_vec;
  logic                 any_hit;
  logic                 miss;

  assign busy    = (state == ST_HUNT);
  assign accept  = start && !busy;
  assign any_hit = |hit_vec;
  assign miss    = chain[SLOTS];
  assign pos_ext = ExtW'(pos);

  // Token seeded into cell 0 on the command beat
  assign chain[0] = accept;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lfsa_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .hunt_in   (chain[i]),
      .match_key (match_key),
      .wr_key    (wr_key),
      .hunt_out  (chain[i+1]),
      .hit       (hit_vec[i])
    );
  end

  // Latch the command: what to look for and what to write back
  always_ff @(posedge clk) begin
    if (accept) begin
      op_delete <= (kind == KIND_DELETE);
      if (kind == KIND_DELETE) begin
        match_key <= KEY_WIDTH'(key);
        wr_key    <= '0;
      end else begin
        match_key <= '0;
        wr_key    <= KEY_WIDTH'(key);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HUNT;
      end
      ST_HUNT: begin
        if (any_hit || miss) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Token position tracker
  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= '0;
    end else if (busy && pos != PosLast) begin
      pos <= pos + 1'b1;
    end
  end

  // Live count and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      live_total <= '0;
    end else begin
      done <= busy && (any_hit || miss);
      if (busy && any_hit) begin
        if (op_delete) begin
          if (live_total != '0) live_total <= live_total - 1'b1;
        end else begin
          if (live_total != COUNT_MAX) live_total <= live_total + 1'b1;
        end
      end
    end
  end

  assign live_count = live_total;

  always_ff @(posedge clk) begin
    if (busy && any_hit) begin
      slot_index <= pos_ext[IDX_W-1:0];
      status     <= STATUS_OK;
    end else if (busy && miss) begin
      slot_index <= '0;
      status     <= op_delete ? STATUS_NOT_FOUND : STATUS_FULL;
    end
  end

`ifndef SYNTHESIS
  // Only one cell can hold the token, so at most one claims it
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell claimed the token");

  // No cell claims while the sequencer is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (hit_vec == '0))
    else $error("cell hit while idle");

  // A result beat follows a hunt that just ended
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_HUNT) && (state == ST_IDLE))
    else $error("result strobe without a finished hunt");

  // Failed commands leave the count alone
  a_fail_count: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> $stable(live_total) && (slot_index == '0))
    else $error("failed command changed the count or reported a slot");
`endif

endmodule

`default_nettype wire
